// ===== design/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define UFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ufc assertion failed");

// checked at every edge, reset included
`define UFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ufc assertion failed");

`endif

// ===== design/ufc_pkg.sv =====
`timescale 1ns / 1ps
package ufc_pkg;

  typedef enum logic [2:0] {
    CMD_RECV  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_STOP  = 3'd4,
    CMD_START = 3'd5
  } ufc_cmd_e;

  typedef enum logic [1:0] {
    OP_NONE       = 2'd0,
    OP_READ       = 2'd1,
    OP_SEND_RTS   = 2'd2,
    OP_SEND_READY = 2'd3
  } ufc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMD  = 2'd1,
    ST_RD   = 2'd2,
    ST_EVAL = 2'd3
  } ufc_state_e;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned WaitW     = 16;
  localparam int unsigned MarkW     = 5;
  localparam int unsigned FillW     = 5;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIdxW-1:0] CFG_READ_WAIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RTS_WAIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_READY_WAIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_MARK  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOW_MARK   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_RTS   = 3'd5;

  localparam logic [WaitW-1:0] READ_WAIT_RST  = 16'd500;
  localparam logic [WaitW-1:0] RTS_WAIT_RST   = 16'd5000;
  localparam logic [WaitW-1:0] READY_WAIT_RST = 16'd500;
  localparam logic [MarkW-1:0] HIGH_MARK_RST  = 5'd13;
  localparam logic [MarkW-1:0] LOW_MARK_RST   = 5'd2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] byte_in;
    logic       rts_level;
    logic       tx_ready;
  } ufc_in_t;

  typedef struct packed {
    logic             done_res;
    logic             op_ok;
    logic [7:0]       read_byte;
    logic             tx_strobe;
    logic [7:0]       tx_byte;
    logic             cts_out;
    logic [FillW-1:0] fill_level;
    logic             overrun;
    logic             data_available;
  } ufc_res_t;

  typedef struct packed {
    logic latch;
    logic push;
    logic pop;
    logic cts_clr;
    logic cts_set;
    logic wait_clr;
    logic wait_inc;
    logic pbyte_load;
    logic out_load;
    logic out_done;
    logic out_ok;
    logic out_strobe;
  } ufc_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       empty;
    logic       rts;
    logic       ready;
    logic       skip;
    logic       over_read;
    logic       over_rts;
    logic       over_ready;
  } ufc_sts_t;

endpackage

// ===== design/ufc_ctrl.sv =====
`timescale 1ns / 1ps
module ufc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ufc_pkg::ufc_sts_t sts_i,
  output ufc_pkg::ufc_ctl_t ctl_o,
  output logic              busy_o,
  output logic              res_valid_o
);
  import ufc_pkg::*;

  ufc_state_e state_q, state_d;
  ufc_op_e    pend_q, pend_d;
  logic       valid_q;
  logic       tick;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= OP_NONE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      valid_q <= (state_q == ST_EVAL);
    end
  end

  assign tick = (sts_i.cmd == CMD_TICK);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.latch = 1'b1;
          state_d     = ST_CMD;
        end
      end
      ST_CMD: begin
        state_d = ST_RD;
        case (sts_i.cmd)
          CMD_RECV: ctl_o.push = 1'b1;
          CMD_READ: begin
            if (pend_q == OP_NONE) begin
              pend_d         = OP_READ;
              ctl_o.wait_clr = 1'b1;
            end
          end
          CMD_SEND: begin
            if (pend_q == OP_NONE) begin
              pend_d           = OP_SEND_RTS;
              ctl_o.wait_clr   = 1'b1;
              ctl_o.pbyte_load = 1'b1;
            end
          end
          CMD_STOP:  ctl_o.cts_clr = 1'b1;
          CMD_START: ctl_o.cts_set = 1'b1;
          default: ;
        endcase
      end
      ST_RD: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d        = ST_IDLE;
        ctl_o.out_load = 1'b1;
        case (pend_q)
          OP_READ: begin
            if (!sts_i.empty) begin
              ctl_o.pop      = 1'b1;
              ctl_o.out_done = 1'b1;
              ctl_o.out_ok   = 1'b1;
              pend_d         = OP_NONE;
            end else if (tick) begin
              ctl_o.wait_inc = 1'b1;
              if (sts_i.over_read) begin
                ctl_o.out_done = 1'b1;
                pend_d         = OP_NONE;
              end
            end
          end
          OP_SEND_RTS: begin
            if (sts_i.rts || sts_i.skip) begin
              if (sts_i.ready) begin
                ctl_o.out_strobe = 1'b1;
                ctl_o.out_done   = 1'b1;
                ctl_o.out_ok     = 1'b1;
                pend_d           = OP_NONE;
              end else begin
                ctl_o.wait_clr = 1'b1;
                pend_d         = OP_SEND_READY;
              end
            end else if (tick) begin
              ctl_o.wait_inc = 1'b1;
              if (sts_i.over_rts) begin
                ctl_o.out_done = 1'b1;
                pend_d         = OP_NONE;
              end
            end
          end
          OP_SEND_READY: begin
            if (sts_i.ready) begin
              ctl_o.out_strobe = 1'b1;
              ctl_o.out_done   = 1'b1;
              ctl_o.out_ok     = 1'b1;
              pend_d           = OP_NONE;
            end else if (tick) begin
              ctl_o.wait_inc = 1'b1;
              if (sts_i.over_ready) begin
                ctl_o.out_done = 1'b1;
                pend_d         = OP_NONE;
              end
            end
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = valid_q;

endmodule

// ===== design/ufc_dpath.sv =====
`timescale 1ns / 1ps
module ufc_dpath #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ufc_pkg::ufc_in_t               in_i,
  input  ufc_pkg::ufc_ctl_t              ctl_i,
  input  logic                           cfg_we_i,
  input  logic [ufc_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [ufc_pkg::CfgDataW-1:0]   cfg_data_i,
  output ufc_pkg::ufc_sts_t              sts_o,
  output ufc_pkg::ufc_res_t              res_o
);
  import ufc_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > MarkW) ? CntW : MarkW;

  logic [7:0]       mem [RING_DEPTH];
  logic [7:0]       rd_q;
  ufc_in_t          in_q;
  logic [IdxW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_inc, cnt_dec;
  logic             cts_q, cts_d;
  logic [WaitW-1:0] wait_q, wait_d, wait_nxt;
  logic             ovr_q, ovr_d;
  logic [7:0]       pbyte_q;
  logic [WaitW-1:0] read_lim_q, rts_lim_q, ready_lim_q;
  logic [MarkW-1:0] high_q, low_q;
  logic             skip_q;
  logic             full, push_ok;
  logic             done_q, ok_q, strobe_q;
  logic [7:0]       rbyte_q, tbyte_q;

  assign full    = (cnt_q == CntW'(RING_DEPTH));
  assign push_ok = ctl_i.push && !full;
  assign cnt_inc = cnt_q + 1'b1;
  assign cnt_dec = cnt_q - 1'b1;
  assign wait_nxt = (wait_q == '1) ? wait_q : wait_q + 1'b1;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    cts_d  = cts_q;
    ovr_d  = ovr_q;
    wait_d = wait_q;
    if (ctl_i.push && full) begin
      ovr_d = 1'b1;
    end
    if (push_ok) begin
      tail_d = (tail_q == IdxW'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      cnt_d  = cnt_inc;
      if (CmpW'(cnt_inc) == CmpW'(high_q)) begin
        cts_d = 1'b0;
      end
    end
    if (ctl_i.pop) begin
      head_d = (head_q == IdxW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
      cnt_d  = cnt_dec;
      if (CmpW'(cnt_dec) == CmpW'(low_q)) begin
        cts_d = 1'b1;
      end
    end
    if (ctl_i.cts_clr) begin
      cts_d = 1'b0;
    end
    if (ctl_i.cts_set) begin
      cts_d = 1'b1;
    end
    if (ctl_i.wait_clr) begin
      wait_d = '0;
    end else if (ctl_i.wait_inc) begin
      wait_d = wait_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      cts_q       <= 1'b1;
      wait_q      <= '0;
      ovr_q       <= 1'b0;
      pbyte_q     <= '0;
      read_lim_q  <= READ_WAIT_RST;
      rts_lim_q   <= RTS_WAIT_RST;
      ready_lim_q <= READY_WAIT_RST;
      high_q      <= HIGH_MARK_RST;
      low_q       <= LOW_MARK_RST;
      skip_q      <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      cts_q  <= cts_d;
      wait_q <= wait_d;
      ovr_q  <= ovr_d;
      if (ctl_i.pbyte_load) begin
        pbyte_q <= in_q.byte_in;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_READ_WAIT:  read_lim_q  <= cfg_data_i;
          CFG_RTS_WAIT:   rts_lim_q   <= cfg_data_i;
          CFG_READY_WAIT: ready_lim_q <= cfg_data_i;
          CFG_HIGH_MARK:  high_q      <= cfg_data_i[MarkW-1:0];
          CFG_LOW_MARK:   low_q       <= cfg_data_i[MarkW-1:0];
          CFG_SKIP_RTS:   skip_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= in_q.byte_in;
    end
    rd_q <= mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      in_q <= in_i;
    end
    if (ctl_i.out_load) begin
      done_q   <= ctl_i.out_done;
      ok_q     <= ctl_i.out_ok;
      strobe_q <= ctl_i.out_strobe;
      rbyte_q  <= ctl_i.pop ? rd_q : 8'd0;
      tbyte_q  <= ctl_i.out_strobe ? pbyte_q : 8'd0;
    end
  end

  assign sts_o.cmd        = in_q.cmd;
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.rts        = in_q.rts_level;
  assign sts_o.ready      = in_q.tx_ready;
  assign sts_o.skip       = skip_q;
  assign sts_o.over_read  = (wait_nxt > read_lim_q);
  assign sts_o.over_rts   = (wait_nxt > rts_lim_q);
  assign sts_o.over_ready = (wait_nxt > ready_lim_q);

  assign res_o.done_res       = done_q;
  assign res_o.op_ok          = ok_q;
  assign res_o.read_byte      = rbyte_q;
  assign res_o.tx_strobe      = strobe_q;
  assign res_o.tx_byte        = tbyte_q;
  assign res_o.cts_out        = cts_q;
  assign res_o.fill_level     = FillW'(cnt_q);
  assign res_o.overrun        = ovr_q;
  assign res_o.data_available = (cnt_q != '0);

endmodule

// ===== design/uart_rx_fifo_flow_control.sv =====
// Receive-side byte ring with RTS/CTS flow control for a serial link.
// Command channel: an item (cmd, byte_in, rts_level, tx_ready) is taken when
// start is high and busy is low. Commands: byte received, read, tick, send,
// stop reception, start reception.
// Each item yields one result on res_o, marked by res_valid_o for exactly one
// cycle, after the controller steps command update, ring read with registered
// read data, pending evaluation and result register. The receiver cannot
// stall: a result not sampled in its cycle is lost. busy drops in the result
// cycle, so a new item can be taken from that cycle on, not before.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_addr_i/cfg_data_i; ready
// is always high, write only while busy is low.
// Reset clears the ring pointers and fill level, raises CTS, drops any
// pending read or send, clears the overrun flag and loads default limits.
`timescale 1ns / 1ps
module uart_rx_fifo_flow_control #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ufc_pkg::ufc_in_t             in_i,
  output logic                         res_valid_o,
  output ufc_pkg::ufc_res_t            res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ufc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [ufc_pkg::CfgDataW-1:0] cfg_data_i
);
  import ufc_pkg::*;

  ufc_ctl_t ctl;
  ufc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ufc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sts_i       (sts),
    .ctl_o       (ctl),
    .busy_o      (busy),
    .res_valid_o (res_valid_o)
  );

  ufc_dpath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .ctl_i      (ctl),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule

// ===== design/ufc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ufc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input ufc_pkg::ufc_res_t res_o
);
  import ufc_pkg::*;

  `UFC_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy)
  `UFC_ASSERT_ALWAYS(a_res_single, clk_i, res_valid_o |=> !res_valid_o)
  `UFC_ASSERT_ALWAYS(a_res_idle, clk_i, res_valid_o |-> !busy)
  `UFC_ASSERT(a_ok_done, clk_i, rst_ni, res_valid_o && res_o.op_ok |-> res_o.done_res)
  `UFC_ASSERT(a_strobe_ok, clk_i, rst_ni, res_valid_o && res_o.tx_strobe |-> res_o.op_ok)

endmodule

bind uart_rx_fifo_flow_control ufc_checker u_ufc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
